@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the scaling index checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define WSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WSI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/wsi_pkg.sv @@
// ----------------------------------------------------------------------------
// wsi_pkg
// Types, constants and helpers of the water scaling index pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsi_pkg;

  localparam int LOG_ITERS = 40;
  localparam int RT_ITERS  = 30;
  localparam int DV_STEPS  = 21;
  localparam int KD_STEPS  = 42;

  // log10(2) in Q60, split for the partial products
  localparam logic [58:0] LOG10_2_Q60 = 59'd347063955532709821;
  localparam logic [29:0] LOG10_2_HI  = LOG10_2_Q60[58:29];
  localparam logic [28:0] LOG10_2_LO  = LOG10_2_Q60[28:0];

  localparam logic signed [24:0] FT_BASE  = 25'sd5394384;
  localparam logic [6:0]         FT_SLOPE = 7'd115;
  localparam logic [24:0]        DEN_BASE = 25'd655360;
  localparam logic [5:0]         DEN_I    = 6'd55;
  localparam logic [13:0]        DEN_SQ   = 14'd13568;
  localparam logic [9:0]         DEN_MUL  = 10'd1000;

  typedef struct packed {
    logic               vld;
    logic               zero;
    logic [15:0]        ph;
    logic [18:0]        is;
    logic [15:0]        t;
    logic signed [16:0] lk;
  } wsi_side_t;

  typedef struct packed {
    wsi_side_t   side;
    logic [31:0] ca;
    logic [31:0] hc;
  } wsi_in_t;

  typedef struct packed {
    logic               vld;
    logic               zero;
    logic [15:0]        ph;
    logic [18:0]        is;
    logic [15:0]        t;
    logic signed [48:0] phs;
  } wsi_lp_t;

  typedef struct packed {
    logic               vld;
    logic               zero;
    logic [15:0]        ph;
    logic signed [48:0] phs;
    logic [41:0]        k40;
  } wsi_sd_t;

  typedef struct packed {
    logic        strobe;
    logic        valid_res;
    logic [19:0] saturation_ph;
    logic [19:0] langelier_index;
    logic [19:0] ryznar_index;
    logic [15:0] stiff_davis_k;
    logic [19:0] corrected_saturation_ph;
    logic [19:0] stiff_davis_index;
  } wsi_res_t;

  // Q40 to Q12, nearest with halves up, saturated to 20 bits
  function automatic logic [19:0] sat_q12(input logic signed [52:0] v);
    logic signed [53:0] w;
    logic signed [25:0] q;
    w = $signed({v[52], v}) + $signed(54'd134217728);
    q = w[53:28];
    if (q > 26'sd524287) begin
      sat_q12 = 20'h7FFFF;
    end else if (q < -26'sd524288) begin
      sat_q12 = 20'h80000;
    end else begin
      sat_q12 = q[19:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ src/wsi_log_path.sv @@
// ----------------------------------------------------------------------------
// wsi_log_path
// Saturation pH: log2 of Ca*HCO3 by squaring, scaled to log10, plus logK.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsi_log_path import wsi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire wsi_in_t in_beat,
  output wsi_lp_t   lp_beat
);

  wsi_side_t   s1_side_r, s2_side_r;
  logic [63:0] s1_prod_r, s2_prod_r;
  logic [5:0]  s2_msb_r;
  logic [5:0]  msb_nxt;
  logic [63:0] norm;

  wsi_side_t             it_side_r [0:LOG_ITERS];
  logic [5:0]            it_msb_r  [0:LOG_ITERS];
  logic [62:0]           it_m_r    [0:LOG_ITERS];
  logic [LOG_ITERS-1:0]  it_frac_r [0:LOG_ITERS];

  wsi_side_t             sq_side_r [0:LOG_ITERS-1];
  logic [5:0]            sq_msb_r  [0:LOG_ITERS-1];
  logic [LOG_ITERS-1:0]  sq_frac_r [0:LOG_ITERS-1];
  logic [61:0]           sq_hh_r   [0:LOG_ITERS-1];
  logic [62:0]           sq_hl_r   [0:LOG_ITERS-1];
  logic [63:0]           sq_ll_r   [0:LOG_ITERS-1];

  wsi_side_t    m0_side_r, m1_side_r, m2_side_r;
  logic         m0_neg_r, m1_neg_r, m2_neg_r;
  logic [45:0]  m0_mag_r;
  logic [52:0]  m1_hh_r, m1_lh_r;
  logic [51:0]  m1_hl_r, m1_ll_r;
  logic [104:0] m2_sa_r, m2_sb_r;
  logic signed [47:0] xv;
  logic [104:0] tot;
  logic signed [45:0] ys;
  wsi_lp_t      lp_r;

  // stage 1: concentration product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.vld <= 1'b0;
    end else begin
      s1_side_r <= in_beat.side;
      s1_prod_r <= in_beat.ca * in_beat.hc;
    end
  end

  always_comb begin
    msb_nxt = '0;
    for (int k = 0; k < 64; k++) begin
      if (s1_prod_r[k]) msb_nxt = 6'(k);
    end
  end

  // stage 2: leading one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.vld <= 1'b0;
    end else begin
      s2_side_r <= s1_side_r;
      s2_prod_r <= s1_prod_r;
      s2_msb_r  <= msb_nxt;
    end
  end

  // stage 3: normalize, mantissa top bit at 62
  assign norm = s2_prod_r << (6'd63 - s2_msb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_side_r[0].vld <= 1'b0;
    end else begin
      it_side_r[0] <= s2_side_r;
      it_msb_r[0]  <= s2_msb_r;
      it_m_r[0]    <= norm[63:1];
      it_frac_r[0] <= '0;
    end
  end

  // one fraction bit per two stages: partial squares, then sum and renormalize
  for (genvar g = 0; g < LOG_ITERS; g++) begin : g_sq
    logic [125:0] sum;
    logic [63:0]  top;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_side_r[g].vld <= 1'b0;
      end else begin
        sq_side_r[g] <= it_side_r[g];
        sq_msb_r[g]  <= it_msb_r[g];
        sq_frac_r[g] <= it_frac_r[g];
        sq_hh_r[g]   <= it_m_r[g][62:32] * it_m_r[g][62:32];
        sq_hl_r[g]   <= it_m_r[g][62:32] * it_m_r[g][31:0];
        sq_ll_r[g]   <= it_m_r[g][31:0] * it_m_r[g][31:0];
      end
    end

    assign sum = {sq_hh_r[g], 64'd0} + 126'({sq_hl_r[g], 33'd0}) + 126'(sq_ll_r[g]);
    assign top = sum[125:62];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_side_r[g+1].vld <= 1'b0;
      end else begin
        it_side_r[g+1] <= sq_side_r[g];
        it_msb_r[g+1]  <= sq_msb_r[g];
        it_m_r[g+1]    <= top[63] ? top[63:1] : top[62:0];
        it_frac_r[g+1] <= {sq_frac_r[g][LOG_ITERS-2:0], top[63]};
      end
    end
  end

  // 48 - log2(product), magnitude and sign
  assign xv = $signed({2'b00, 6'd48, 40'd0})
            - $signed({2'b00, it_msb_r[LOG_ITERS], it_frac_r[LOG_ITERS]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_side_r.vld <= 1'b0;
    end else begin
      m0_side_r <= it_side_r[LOG_ITERS];
      m0_neg_r  <= xv[47];
      m0_mag_r  <= xv[47] ? 46'(-xv) : xv[45:0];
    end
  end

  // scale by log10(2): four partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_side_r.vld <= 1'b0;
    end else begin
      m1_side_r <= m0_side_r;
      m1_neg_r  <= m0_neg_r;
      m1_hh_r   <= m0_mag_r[45:23] * LOG10_2_HI;
      m1_hl_r   <= m0_mag_r[45:23] * LOG10_2_LO;
      m1_lh_r   <= m0_mag_r[22:0] * LOG10_2_HI;
      m1_ll_r   <= m0_mag_r[22:0] * LOG10_2_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_side_r.vld <= 1'b0;
    end else begin
      m2_side_r <= m1_side_r;
      m2_neg_r  <= m1_neg_r;
      m2_sa_r   <= {m1_hh_r, 52'd0} + 105'(m1_ll_r);
      m2_sb_r   <= 105'({m1_hl_r, 23'd0}) + 105'({m1_lh_r, 29'd0});
    end
  end

  assign tot = m2_sa_r + m2_sb_r;
  assign ys  = m2_neg_r ? -$signed({1'b0, tot[104:60]}) : $signed({1'b0, tot[104:60]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r.vld <= 1'b0;
    end else begin
      lp_r.vld  <= m2_side_r.vld;
      lp_r.zero <= m2_side_r.zero;
      lp_r.ph   <= m2_side_r.ph;
      lp_r.is   <= m2_side_r.is;
      lp_r.t    <= m2_side_r.t;
      lp_r.phs  <= $signed({{4{m2_side_r.lk[16]}}, m2_side_r.lk, 28'd0})
                 + $signed({{3{ys[45]}}, ys});
    end
  end

  assign lp_beat = lp_r;

endmodule

`default_nettype wire

@@ src/wsi_sd_path.sv @@
// ----------------------------------------------------------------------------
// wsi_sd_path
// Stiff-Davis correction: square root, fraction and temperature factor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsi_sd_path import wsi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire wsi_lp_t lp_beat,
  output wsi_sd_t      sd_beat
);

  logic signed [24:0] f_nxt;
  logic               kz;

  wsi_lp_t     rt_side_r [0:RT_ITERS];
  logic [59:0] rt_v_r    [0:RT_ITERS];
  logic [59:0] rt_r_r    [0:RT_ITERS];
  logic [23:0] rt_f2_r   [0:RT_ITERS];

  wsi_lp_t     dv_side_r [0:DV_STEPS];
  logic [30:0] dv_rem_r  [0:DV_STEPS];
  logic [29:0] dv_rt_r   [0:DV_STEPS];
  logic [20:0] dv_q_r    [0:DV_STEPS];
  logic [23:0] dv_f2_r   [0:DV_STEPS];
  logic        dv_e0_r;

  wsi_lp_t     s1_side_r, s2_side_r, s3_side_r;
  logic [49:0] s1_s_r;
  logic [24:0] s1_a_r, s2_a_r;
  logic [23:0] s1_f2_r;
  logic [63:0] s2_s13_r;
  logic [48:0] s2_phi_r, s2_plo_r;
  logic [45:0] s3_dq_r;
  logic [73:0] s3_np_r;

  wsi_lp_t     kd_side_r [0:KD_STEPS];
  logic [55:0] kd_rem_r  [0:KD_STEPS];
  logic [55:0] kd_d_r    [0:KD_STEPS];
  logic [21:0] kd_nl_r   [0:KD_STEPS];
  logic [41:0] kd_q_r    [0:KD_STEPS];

  // temperature factor, zero correction for no ionic strength or hot water
  assign f_nxt = FT_BASE - $signed({1'b0, 24'(lp_beat.t) * 24'(FT_SLOPE)});
  assign kz    = (lp_beat.is == '0) || (f_nxt <= 25'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_side_r[0].vld <= 1'b0;
    end else begin
      rt_side_r[0] <= lp_beat;
      rt_v_r[0]    <= {1'b0, lp_beat.is, 40'd0};
      rt_r_r[0]    <= '0;
      rt_f2_r[0]   <= kz ? 24'd0 : {f_nxt[22:0], 1'b0};
    end
  end

  // integer square root, one result bit per stage
  for (genvar g = 0; g < RT_ITERS; g++) begin : g_rt
    localparam logic [59:0] RtBit = 60'(1) << (58 - 2 * g);
    logic [59:0] sum;
    logic        ge;

    assign sum = rt_r_r[g] + RtBit;
    assign ge  = rt_v_r[g] >= sum;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rt_side_r[g+1].vld <= 1'b0;
      end else begin
        rt_side_r[g+1] <= rt_side_r[g];
        rt_f2_r[g+1]   <= rt_f2_r[g];
        rt_v_r[g+1]    <= ge ? rt_v_r[g] - sum : rt_v_r[g];
        rt_r_r[g+1]    <= ge ? (rt_r_r[g] >> 1) + RtBit : rt_r_r[g] >> 1;
      end
    end
  end

  // remainder over twice the root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_side_r[0].vld <= 1'b0;
    end else begin
      dv_side_r[0] <= rt_side_r[RT_ITERS];
      dv_f2_r[0]   <= rt_f2_r[RT_ITERS];
      dv_rem_r[0]  <= {1'b0, rt_v_r[RT_ITERS][30:1]};
      dv_e0_r      <= rt_v_r[RT_ITERS][0];
      dv_rt_r[0]   <= rt_r_r[RT_ITERS][29:0];
      dv_q_r[0]    <= '0;
    end
  end

  for (genvar g = 0; g < DV_STEPS; g++) begin : g_dv
    logic        nb;
    logic [31:0] rem_sh;
    logic [31:0] den;
    logic        ge;

    if (g == 0) begin : g_first
      assign nb = dv_e0_r;
    end else begin : g_rest
      assign nb = 1'b0;
    end

    assign rem_sh = {dv_rem_r[g], nb};
    assign den    = {1'b0, dv_rt_r[g], 1'b0};
    assign ge     = rem_sh >= den;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_side_r[g+1].vld <= 1'b0;
      end else begin
        dv_side_r[g+1] <= dv_side_r[g];
        dv_f2_r[g+1]   <= dv_f2_r[g];
        dv_rt_r[g+1]   <= dv_rt_r[g];
        dv_rem_r[g+1]  <= ge ? 31'(rem_sh - den) : rem_sh[30:0];
        dv_q_r[g+1]    <= {dv_q_r[g][19:0], ge};
      end
    end
  end

  // root in Q40 and the linear part of the denominator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.vld <= 1'b0;
    end else begin
      s1_side_r <= dv_side_r[DV_STEPS];
      s1_f2_r   <= dv_f2_r[DV_STEPS];
      s1_s_r    <= {dv_rt_r[DV_STEPS], 20'd0} + 50'(dv_q_r[DV_STEPS]);
      s1_a_r    <= DEN_BASE + 25'(dv_side_r[DV_STEPS].is) * 25'(DEN_I);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.vld <= 1'b0;
    end else begin
      s2_side_r <= s1_side_r;
      s2_a_r    <= s1_a_r;
      s2_s13_r  <= 64'(s1_s_r) * 64'(DEN_SQ);
      s2_phi_r  <= s1_s_r[49:25] * s1_f2_r;
      s2_plo_r  <= s1_s_r[24:0] * s1_f2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r.vld <= 1'b0;
    end else begin
      s3_side_r <= s2_side_r;
      s3_dq_r   <= 46'({s2_a_r, 20'd0}) + 46'(s2_s13_r[63:20]);
      s3_np_r   <= 74'({s2_phi_r, 25'd0}) + 74'(s2_plo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kd_side_r[0].vld <= 1'b0;
    end else begin
      kd_side_r[0] <= s3_side_r;
      kd_d_r[0]    <= 56'(s3_dq_r) * 56'(DEN_MUL);
      kd_rem_r[0]  <= 56'(s3_np_r[73:22]);
      kd_nl_r[0]   <= s3_np_r[21:0];
      kd_q_r[0]    <= '0;
    end
  end

  // correction quotient, one bit per stage
  for (genvar g = 0; g < KD_STEPS; g++) begin : g_kd
    logic        nb;
    logic [56:0] rem_sh;
    logic        ge;

    if (g <= 21) begin : g_num
      assign nb = kd_nl_r[g][21-g];
    end else begin : g_pad
      assign nb = 1'b0;
    end

    assign rem_sh = {kd_rem_r[g], nb};
    assign ge     = rem_sh >= {1'b0, kd_d_r[g]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kd_side_r[g+1].vld <= 1'b0;
      end else begin
        kd_side_r[g+1] <= kd_side_r[g];
        kd_d_r[g+1]    <= kd_d_r[g];
        kd_nl_r[g+1]   <= kd_nl_r[g];
        kd_rem_r[g+1]  <= ge ? 56'(rem_sh - {1'b0, kd_d_r[g]}) : rem_sh[55:0];
        kd_q_r[g+1]    <= {kd_q_r[g][40:0], ge};
      end
    end
  end

  assign sd_beat.vld  = kd_side_r[KD_STEPS].vld;
  assign sd_beat.zero = kd_side_r[KD_STEPS].zero;
  assign sd_beat.ph   = kd_side_r[KD_STEPS].ph;
  assign sd_beat.phs  = kd_side_r[KD_STEPS].phs;
  assign sd_beat.k40  = kd_q_r[KD_STEPS];

endmodule

`default_nettype wire

@@ src/wsi_out.sv @@
// ----------------------------------------------------------------------------
// wsi_out
// Index differences, rounding to Q12 and saturation of the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsi_out import wsi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire wsi_sd_t sd_beat,
  output wsi_res_t     res
);

  logic signed [52:0] ph40, phsx, kx;
  logic               o1_vld_r, o1_zero_r;
  logic [41:0]        o1_k_r;
  logic signed [52:0] o1_sat_r, o1_li_r, o1_ri_r, o1_cp_r, o1_sdi_r;
  logic [42:0]        kw;
  wsi_res_t           res_r;

  assign ph40 = $signed({9'd0, sd_beat.ph, 28'd0});
  assign phsx = $signed({{4{sd_beat.phs[48]}}, sd_beat.phs});
  assign kx   = $signed({11'd0, sd_beat.k40});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_vld_r <= 1'b0;
    end else begin
      o1_vld_r  <= sd_beat.vld;
      o1_zero_r <= sd_beat.zero;
      o1_k_r    <= sd_beat.k40;
      o1_sat_r  <= phsx;
      o1_li_r   <= ph40 - phsx;
      o1_ri_r   <= (phsx <<< 1) - ph40;
      o1_cp_r   <= phsx + kx;
      o1_sdi_r  <= ph40 - phsx - kx;
    end
  end

  assign kw = {1'b0, o1_k_r} + 43'd134217728;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.strobe <= 1'b0;
    end else begin
      res_r.strobe <= o1_vld_r;
      if (o1_zero_r) begin
        res_r.valid_res               <= 1'b0;
        res_r.saturation_ph           <= '0;
        res_r.langelier_index         <= '0;
        res_r.ryznar_index            <= '0;
        res_r.stiff_davis_k           <= '0;
        res_r.corrected_saturation_ph <= '0;
        res_r.stiff_davis_index       <= '0;
      end else begin
        res_r.valid_res               <= 1'b1;
        res_r.saturation_ph           <= sat_q12(o1_sat_r);
        res_r.langelier_index         <= sat_q12(o1_li_r);
        res_r.ryznar_index            <= sat_q12(o1_ri_r);
        res_r.stiff_davis_k           <= 16'(kw[42:28]);
        res_r.corrected_saturation_ph <= sat_q12(o1_cp_r);
        res_r.stiff_davis_index       <= sat_q12(o1_sdi_r);
      end
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

@@ src/water_scaling_index_unit.sv @@
// ----------------------------------------------------------------------------
// water_scaling_index_unit
// Langelier, Ryznar and Stiff-Davis scaling indices from one water sample.
// ----------------------------------------------------------------------------
// A sample is taken on any edge with start high and busy low; busy is high only
// during reset and the first cycle after it, so one sample per clock is taken.
// Each sample gives one result beat, flagged by out_strobe for one cycle;
// results come out in sample order and cannot be held off. The pipeline
// depth is set by the 40 two-stage squaring steps of the logarithm and the
// bit-per-stage square root and divisions of the Stiff-Davis correction.
`timescale 1ns / 1ps
`default_nettype none

module water_scaling_index_unit import wsi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_ph_value,
  input  wire logic [31:0] in_calcium_conc,
  input  wire logic [31:0] in_bicarbonate_conc,
  input  wire logic signed [19:0] in_ionic_strength,
  input  wire logic [15:0] in_temperature_kelvin,
  input  wire logic signed [16:0] in_log_k_calcite,
  output logic             out_strobe,
  output logic             out_valid_res,
  output logic signed [19:0] out_saturation_ph,
  output logic signed [19:0] out_langelier_index,
  output logic signed [19:0] out_ryznar_index,
  output logic [15:0]      out_stiff_davis_k,
  output logic signed [19:0] out_corrected_saturation_ph,
  output logic signed [19:0] out_stiff_davis_index
);

  logic     busy_r;
  wsi_in_t  in_beat;
  wsi_lp_t  lp_beat;
  wsi_sd_t  sd_beat;
  wsi_res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  always_comb begin
    in_beat.side.vld  = start & ~busy_r;
    in_beat.side.zero = (in_calcium_conc == '0) || (in_bicarbonate_conc == '0);
    in_beat.side.ph   = in_ph_value;
    in_beat.side.is   = in_ionic_strength[19] ? 19'd0 : in_ionic_strength[18:0];
    in_beat.side.t    = in_temperature_kelvin;
    in_beat.side.lk   = in_log_k_calcite;
    in_beat.ca        = in_calcium_conc;
    in_beat.hc        = in_bicarbonate_conc;
  end

  wsi_log_path u_log (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .lp_beat (lp_beat)
  );

  wsi_sd_path u_sd (
    .clk     (clk),
    .rst_n   (rst_n),
    .lp_beat (lp_beat),
    .sd_beat (sd_beat)
  );

  wsi_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .sd_beat (sd_beat),
    .res     (res)
  );

  assign out_strobe                  = res.strobe;
  assign out_valid_res               = res.valid_res;
  assign out_saturation_ph           = res.saturation_ph;
  assign out_langelier_index         = res.langelier_index;
  assign out_ryznar_index            = res.ryznar_index;
  assign out_stiff_davis_k           = res.stiff_davis_k;
  assign out_corrected_saturation_ph = res.corrected_saturation_ph;
  assign out_stiff_davis_index       = res.stiff_davis_index;

endmodule

`default_nettype wire

@@ src/wsi_chk.sv @@
// ----------------------------------------------------------------------------
// wsi_chk
// Port-level checks of the scaling index unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wsi_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic        out_valid_res,
  input wire logic [19:0] out_saturation_ph,
  input wire logic [19:0] out_langelier_index,
  input wire logic [19:0] out_ryznar_index,
  input wire logic [15:0] out_stiff_davis_k,
  input wire logic [19:0] out_corrected_saturation_ph,
  input wire logic [19:0] out_stiff_davis_index
);

  logic fields_zero;

  assign fields_zero = (out_saturation_ph == 20'd0) && (out_langelier_index == 20'd0)
                    && (out_ryznar_index == 20'd0) && (out_stiff_davis_k == 16'd0)
                    && (out_corrected_saturation_ph == 20'd0)
                    && (out_stiff_davis_index == 20'd0);

  `WSI_ASSERT_RST(a_rst_busy, !rst_n |=> busy, "busy low right after reset")
  `WSI_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_strobe, "result beat right after reset")
  `WSI_ASSERT(a_absent_zero, (out_strobe && !out_valid_res) |-> fields_zero, "absent beat with nonzero fields")
  `WSI_ASSERT(a_k_bound, out_strobe |-> (out_stiff_davis_k < 16'd2048), "correction out of bound")

endmodule

bind water_scaling_index_unit wsi_chk u_chk (.*);

`default_nettype wire
